/* hdl/bnms_pkg.sv */
package bnms_pkg;

  // Storage and coordinate sizes.
  localparam int MAX_BOXES  = 64;
  localparam int COORD_BITS = 12;
  localparam int IDX_W      = $clog2(MAX_BOXES);
  localparam int CNT_W      = $clog2(MAX_BOXES + 1);
  localparam int SIZE_W     = COORD_BITS + 1;
  localparam int AREA_W     = 2 * SIZE_W;
  localparam int RATIO_W    = 9;
  localparam int FRAC_W     = 8;
  localparam int CMP_W      = AREA_W + RATIO_W;

  // Reset value of the suppression ratio: 0.8 in Q8, rounded to nearest.
  localparam logic [RATIO_W-1:0] RATIO_RESET = RATIO_W'(205);

  // One stored box with its area.
  typedef struct packed {
    logic [COORD_BITS-1:0] x0;
    logic [COORD_BITS-1:0] y0;
    logic [COORD_BITS-1:0] x1;
    logic [COORD_BITS-1:0] y1;
    logic [AREA_W-1:0]     area;
  } box_t;

  localparam int BOX_W = $bits(box_t);

  // Sequencer states.
  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_FLUSH = 14'b00000000000010,
    S_SCAN  = 14'b00000000000100,
    S_PLACE = 14'b00000000001000,
    S_ISEL  = 14'b00000000010000,
    S_R1WT  = 14'b00000000100000,
    S_JSEL  = 14'b00000001000000,
    S_JWT   = 14'b00000010000000,
    S_GEO   = 14'b00000100000000,
    S_MUL   = 14'b00001000000000,
    S_CMP   = 14'b00010000000000,
    S_ESEL  = 14'b00100000000000,
    S_EWT   = 14'b01000000000000,
    S_OUT   = 14'b10000000000000
  } state_t;

  // Width of a box from its edges, max - min + 1.
  function automatic logic [SIZE_W-1:0] span(input logic [COORD_BITS-1:0] lo,
                                             input logic [COORD_BITS-1:0] hi);
    span = {1'b0, hi} - {1'b0, lo} + SIZE_W'(1);
  endfunction

endpackage

/* hdl/bnms_ram.sv */
module bnms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* hdl/box_non_maximum_suppression_unit.sv */
// Box non-maximum suppression. Cluster points enter one per cycle while the block is idle;
// each closed cluster becomes a bounding box in the box memory, up to 64 boxes per set;
// a point with set_end stalls the input until all surviving boxes have been delivered.
// After set end the block passes through a flush state, then sorts by area, largest first,
// with n selection passes over the box memory read port (n stored boxes), each a scan of
// the unplaced boxes and a placing step. It then runs the greedy suppression with one
// shared geometry and multiply datapath for all compared pairs, then delivers each
// survivor, holding it while the output is stalled.
// The ratio register may only be written while the block is idle.
module box_non_maximum_suppression_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [bnms_pkg::COORD_BITS-1:0]   pos_x,
  input  logic [bnms_pkg::COORD_BITS-1:0]   pos_y,
  input  logic                              cluster_end,
  input  logic                              set_end,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [bnms_pkg::COORD_BITS-1:0]   box_left,
  output logic [bnms_pkg::COORD_BITS-1:0]   box_top,
  output logic [bnms_pkg::SIZE_W-1:0]       box_width,
  output logic [bnms_pkg::SIZE_W-1:0]       box_height,
  output logic                              last_box,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bnms_pkg::RATIO_W-1:0]      overlap_ratio_q8
);

  localparam int CB = bnms_pkg::COORD_BITS;
  localparam int IW = bnms_pkg::IDX_W;
  localparam int CW = bnms_pkg::CNT_W;
  localparam int NB = bnms_pkg::MAX_BOXES;

  bnms_pkg::state_t state;

  logic [bnms_pkg::RATIO_W-1:0] ratio;
  logic [CB-1:0] bx0, by0, bx1, by1;
  logic [CB-1:0] nx0, ny0, nx1, ny1;
  logic          in_acc;

  logic             pend_valid;
  bnms_pkg::box_t   pend;
  logic [IW-1:0]    pend_addr;
  bnms_pkg::box_t   pend_full;
  logic [CW-1:0]    count;

  logic [CW-1:0]    scan_k;
  logic             d_valid;
  logic [IW-1:0]    d_idx;
  logic             have;
  bnms_pkg::box_t   best;
  logic [IW-1:0]    best_idx;
  logic [CW-1:0]    rank;
  logic [NB-1:0]    placed;
  logic [NB-1:0]    alive;
  logic [NB-1:0]    count_mask;
  logic [NB-1:0]    above;

  logic [CW-1:0]    i_idx;
  logic [CW-1:0]    j_idx;
  bnms_pkg::box_t   r1, r2;
  logic [bnms_pkg::SIZE_W-1:0] iw, ih;
  logic [bnms_pkg::AREA_W-1:0] inter;
  logic [bnms_pkg::CMP_W-1:0]  rhs;

  bnms_pkg::box_t   box_rd;
  bnms_pkg::box_t   srt_rd;
  logic [IW-1:0]    srt_rd_addr;

  logic [CB-1:0] lx, ly, hx, hy;

  // Running bounds including the point on the input.
  assign in_acc = in_valid && !in_stall;
  assign nx0 = (pos_x < bx0) ? pos_x : bx0;
  assign ny0 = (pos_y < by0) ? pos_y : by0;
  assign nx1 = (pos_x > bx1) ? pos_x : bx1;
  assign ny1 = (pos_y > by1) ? pos_y : by1;

  assign in_stall  = (state != bnms_pkg::S_IDLE);
  assign cfg_ready = 1'b1;

  // Area of the pending box, written into the box memory in the cycle after its close.
  always_comb begin
    pend_full      = pend;
    pend_full.area = bnms_pkg::span(pend.x0, pend.x1) * bnms_pkg::span(pend.y0, pend.y1);
  end

  bnms_ram #(.WIDTH(bnms_pkg::BOX_W), .DEPTH(NB)) u_box_ram (
    .clk     (clk),
    .wr_en   (pend_valid),
    .wr_addr (pend_addr),
    .wr_data (pend_full),
    .rd_addr (scan_k[IW-1:0]),
    .rd_data (box_rd)
  );

  // Read address of the sorted memory follows the walk that is running.
  always_comb begin
    unique case (state)
      bnms_pkg::S_JSEL: srt_rd_addr = j_idx[IW-1:0];
      default:          srt_rd_addr = i_idx[IW-1:0];
    endcase
  end

  bnms_ram #(.WIDTH(bnms_pkg::BOX_W), .DEPTH(NB)) u_sorted_ram (
    .clk     (clk),
    .wr_en   (state == bnms_pkg::S_PLACE),
    .wr_addr (rank[IW-1:0]),
    .wr_data (best),
    .rd_addr (srt_rd_addr),
    .rd_data (srt_rd)
  );

  // Ranks below the box count, and live ranks after the one being delivered.
  always_comb begin
    for (int b = 0; b < NB; b++) begin
      count_mask[b] = (CW'(b) < count);
      above[b]      = alive[b] && (CW'(b) > i_idx);
    end
  end

  // Intersection bounds of the reference box and the candidate.
  assign lx = (r1.x0 > r2.x0) ? r1.x0 : r2.x0;
  assign ly = (r1.y0 > r2.y0) ? r1.y0 : r2.y0;
  assign hx = (r1.x1 < r2.x1) ? r1.x1 : r2.x1;
  assign hy = (r1.y1 < r2.y1) ? r1.y1 : r2.y1;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      ratio <= bnms_pkg::RATIO_RESET;
    end else if (cfg_valid && cfg_ready) begin
      ratio <= overlap_ratio_q8;
    end
  end

  // Payload registers of the sequencer.
  always_ff @(posedge clk) begin
    if (in_acc && (cluster_end || set_end)) begin
      pend      <= '{x0: nx0, y0: ny0, x1: nx1, y1: ny1, area: '0};
      pend_addr <= count[IW-1:0];
    end
    d_idx <= scan_k[IW-1:0];
    if (state == bnms_pkg::S_SCAN && d_valid && !placed[d_idx] &&
        (!have || box_rd.area > best.area)) begin
      best     <= box_rd;
      best_idx <= d_idx;
    end
    if (state == bnms_pkg::S_R1WT) begin
      r1 <= srt_rd;
    end
    if (state == bnms_pkg::S_JWT) begin
      r2 <= srt_rd;
    end
    if (state == bnms_pkg::S_GEO) begin
      iw <= (lx > hx || ly > hy) ? '0 : bnms_pkg::span(lx, hx);
      ih <= (lx > hx || ly > hy) ? '0 : bnms_pkg::span(ly, hy);
    end
    if (state == bnms_pkg::S_MUL) begin
      inter <= iw * ih;
      rhs   <= ratio * r2.area;
    end
    if (state == bnms_pkg::S_EWT) begin
      box_left   <= srt_rd.x0;
      box_top    <= srt_rd.y0;
      box_width  <= bnms_pkg::span(srt_rd.x0, srt_rd.x1);
      box_height <= bnms_pkg::span(srt_rd.y0, srt_rd.y1);
      last_box   <= ~|above;
    end
  end

  // Control: point intake, selection sort, greedy suppression and delivery.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= bnms_pkg::S_IDLE;
      bx0        <= '1;
      by0        <= '1;
      bx1        <= '0;
      by1        <= '0;
      pend_valid <= 1'b0;
      count      <= '0;
      scan_k     <= '0;
      d_valid    <= 1'b0;
      have       <= 1'b0;
      rank       <= '0;
      placed     <= '0;
      alive      <= '0;
      i_idx      <= '0;
      j_idx      <= '0;
      out_valid  <= 1'b0;
    end else begin
      pend_valid <= 1'b0;
      unique case (state)
        bnms_pkg::S_IDLE: begin
          if (in_acc) begin
            if (cluster_end || set_end) begin
              bx0        <= '1;
              by0        <= '1;
              bx1        <= '0;
              by1        <= '0;
              pend_valid <= (count < CW'(NB));
              if (count < CW'(NB)) begin
                count <= count + CW'(1);
              end
            end else begin
              bx0 <= nx0;
              by0 <= ny0;
              bx1 <= nx1;
              by1 <= ny1;
            end
            if (set_end) begin
              state <= bnms_pkg::S_FLUSH;
            end
          end
        end
        bnms_pkg::S_FLUSH: begin
          rank    <= '0;
          scan_k  <= '0;
          d_valid <= 1'b0;
          have    <= 1'b0;
          state   <= bnms_pkg::S_SCAN;
        end
        bnms_pkg::S_SCAN: begin
          // One box memory read a cycle; the largest unplaced box wins, earliest on a tie.
          d_valid <= (scan_k < count);
          if (scan_k < count) begin
            scan_k <= scan_k + CW'(1);
          end
          if (d_valid && !placed[d_idx] && (!have || box_rd.area > best.area)) begin
            have <= 1'b1;
          end
          if (scan_k == count && !d_valid) begin
            state <= bnms_pkg::S_PLACE;
          end
        end
        bnms_pkg::S_PLACE: begin
          placed[best_idx] <= 1'b1;
          rank             <= rank + CW'(1);
          scan_k           <= '0;
          d_valid          <= 1'b0;
          have             <= 1'b0;
          if (rank + CW'(1) == count) begin
            alive <= count_mask;
            i_idx <= '0;
            state <= bnms_pkg::S_ISEL;
          end else begin
            state <= bnms_pkg::S_SCAN;
          end
        end
        bnms_pkg::S_ISEL: begin
          if (i_idx == count) begin
            i_idx <= '0;
            state <= bnms_pkg::S_ESEL;
          end else if (!alive[i_idx[IW-1:0]]) begin
            i_idx <= i_idx + CW'(1);
          end else begin
            state <= bnms_pkg::S_R1WT;
          end
        end
        bnms_pkg::S_R1WT: begin
          j_idx <= i_idx + CW'(1);
          state <= bnms_pkg::S_JSEL;
        end
        bnms_pkg::S_JSEL: begin
          if (j_idx == count) begin
            i_idx <= i_idx + CW'(1);
            state <= bnms_pkg::S_ISEL;
          end else if (!alive[j_idx[IW-1:0]]) begin
            j_idx <= j_idx + CW'(1);
          end else begin
            state <= bnms_pkg::S_JWT;
          end
        end
        bnms_pkg::S_JWT: begin
          state <= bnms_pkg::S_GEO;
        end
        bnms_pkg::S_GEO: begin
          state <= bnms_pkg::S_MUL;
        end
        bnms_pkg::S_MUL: begin
          state <= bnms_pkg::S_CMP;
        end
        bnms_pkg::S_CMP: begin
          // Drop the candidate when the overlap exceeds the ratio of its own area.
          if ({1'b0, inter, {bnms_pkg::FRAC_W{1'b0}}} > rhs) begin
            alive[j_idx[IW-1:0]] <= 1'b0;
          end
          j_idx <= j_idx + CW'(1);
          state <= bnms_pkg::S_JSEL;
        end
        bnms_pkg::S_ESEL: begin
          if (i_idx == count) begin
            count  <= '0;
            placed <= '0;
            alive  <= '0;
            state  <= bnms_pkg::S_IDLE;
          end else if (!alive[i_idx[IW-1:0]]) begin
            i_idx <= i_idx + CW'(1);
          end else begin
            state <= bnms_pkg::S_EWT;
          end
        end
        bnms_pkg::S_EWT: begin
          out_valid <= 1'b1;
          state     <= bnms_pkg::S_OUT;
        end
        bnms_pkg::S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            i_idx     <= i_idx + CW'(1);
            state     <= bnms_pkg::S_ESEL;
          end
        end
        default: begin
          state <= bnms_pkg::S_IDLE;
        end
      endcase
    end
  end

endmodule

/* hdl/bnms_checker.sv */
module bnms_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic set_end,
  input logic out_valid,
  input logic out_stall,
  input logic last_box
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result withdrawn while stalled");

  // No request is taken while a result is being offered.
  a_out_blocks_in: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input open while a result is offered");

  // The end of a set closes the input.
  a_set_end_stalls: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && set_end |=> in_stall)
    else $error("input still open after set end");

  // Nothing follows the final box straight away.
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && last_box |=> !out_valid)
    else $error("result offered right after the final box");

endmodule

bind box_non_maximum_suppression_unit bnms_checker u_bnms_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .set_end   (set_end),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .last_box  (last_box)
);
